[rtl/core/stq_pkg.sv]
// sorted timeout queue package: widths, codes, cell control and link types
// no dependencies; imported by every module of the block
package stq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int MAX_RESULTS = 32;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam int HANDLE_W = 5;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   // broadcast to every cell
   typedef struct packed {
      logic                insert;
      logic                pop;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   key;
   } stq_ctrl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic                valid;
      logic                keep;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   expiry;
   } stq_link_type;

endpackage

[rtl/core/sorted_timeout_queue.sv]
// sorted timeout queue top: request decode, sequencer, chain of cells, result register
// a request transfer loads the sequencer, which then fills the result register
// service: head checked in the service state, then one released entry per cycle from the
// head cell while the result register is free; one request at a time, taken only in idle
// reset clears sequencer, result valid and every cell's occupancy flag
// depends on stq_pkg and stq_cell
module sorted_timeout_queue import stq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_operation,
   input  logic [HANDLE_W-1:0] req_message_handle,
   input  logic [TIME_W-1:0]   req_delay_ticks,
   input  logic [TIME_W-1:0]   req_current_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [HANDLE_W-1:0] rsp_released_handle,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last_of_run
);

   // sequencer states
   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_INSERT  = 2'd1;
   localparam logic [1:0] S_SERVICE = 2'd2;

   localparam logic [CNT_W-1:0] REL_LAST = CNT_W'(MAX_RESULTS - 1);

   logic [1:0]          state_ff, state_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   // insert: absolute expiry; service: current time
   logic [TIME_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]    rel_cnt_ff, rel_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   stq_ctrl_type ctrl;
   stq_link_type links [QUEUE_DEPTH];
   stq_link_type head_link;
   stq_link_type tail_link;

   logic req_xfer;
   logic out_free;
   logic full;
   logic head_expired;
   logic next_expired;
   logic last_release;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_xfer     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign full         = links[QUEUE_DEPTH-1].valid;
   // the cell compare against the key doubles as the expired test on service
   assign head_expired = links[0].keep;
   assign next_expired = links[1].keep;
   assign last_release = !next_expired || (rel_cnt_ff == REL_LAST);

   // boundary links: head sees a keeping neighbor so it takes the new entry, tail sees empty
   always_comb begin
      head_link        = '0;
      head_link.valid  = 1'b1;
      head_link.keep   = 1'b1;
      tail_link        = '0;
   end

   always_comb begin
      ctrl.insert = (state_ff == S_INSERT) && out_free && !full;
      ctrl.pop    = (state_ff == S_SERVICE) && out_free && head_expired;
      ctrl.handle = handle_ff;
      ctrl.key    = key_ff;
   end

   // chain of cells, entry 0 at the head
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      stq_link_type prev_l;
      stq_link_type next_l;
      if (i == 0) begin : g_first
         assign prev_l = head_link;
      end else begin : g_mid_prev
         assign prev_l = links[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_l = tail_link;
      end else begin : g_mid_next
         assign next_l = links[i+1];
      end
      stq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_link (prev_l),
         .next_link (next_l),
         .link      (links[i])
      );
   end

   // sequencer and result register
   always_comb begin
      state_in      = state_ff;
      handle_in     = handle_ff;
      key_in        = key_ff;
      rel_cnt_in    = rel_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               handle_in  = req_message_handle;
               rel_cnt_in = '0;
               if (req_operation == OP_INSERT) begin
                  // wraps modulo 2^32
                  key_in   = req_delay_ticks + req_current_time;
                  state_in = S_INSERT;
               end else begin
                  key_in   = req_current_time;
                  state_in = S_SERVICE;
               end
            end
         end
         S_INSERT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = handle_ff;
               rsp_status_in = full ? STATUS_REJECTED : STATUS_ACCEPTED;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_SERVICE: begin
            if (!head_expired || (rel_cnt_ff == '0 && !head_expired)) begin
               // nothing (more) due, no transfer for this request
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = links[0].handle;
               rsp_status_in = STATUS_RELEASED;
               rsp_last_in   = last_release;
               rel_cnt_in    = rel_cnt_ff + 1'b1;
               if (last_release) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rel_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rel_cnt_ff   <= rel_cnt_in;
      end
      handle_ff     <= handle_in;
      key_ff        <= key_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_released_handle = rsp_handle_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_last_of_run     = rsp_last_ff;

endmodule

[rtl/core/stq_cell.sv]
// one slot of the sorted chain: holds an entry, compares it with the broadcast key
// depends on stq_pkg
module stq_cell import stq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  stq_ctrl_type ctrl,
   input  stq_link_type prev_link,
   input  stq_link_type next_link,
   output stq_link_type link
);

   logic                valid_ff, valid_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [TIME_W-1:0]   expiry_ff, expiry_in;
   logic                keep;

   // entry stays ahead of an insert, or is expired on service
   assign keep = valid_ff && (expiry_ff <= ctrl.key);

   always_comb begin
      valid_in  = valid_ff;
      handle_in = handle_ff;
      expiry_in = expiry_ff;
      priority if (ctrl.pop) begin
         valid_in  = next_link.valid;
         handle_in = next_link.handle;
         expiry_in = next_link.expiry;
      end else if (ctrl.insert && !keep) begin
         if (prev_link.keep) begin
            valid_in  = 1'b1;
            handle_in = ctrl.handle;
            expiry_in = ctrl.key;
         end else begin
            valid_in  = prev_link.valid;
            handle_in = prev_link.handle;
            expiry_in = prev_link.expiry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      handle_ff <= handle_in;
      expiry_ff <= expiry_in;
   end

   always_comb begin
      link.valid  = valid_ff;
      link.keep   = keep;
      link.handle = handle_ff;
      link.expiry = expiry_ff;
   end

endmodule

[rtl/core/stq_checker.sv]
// port-level checks for the sorted timeout queue, bound to the top level
// depends on stq_pkg and sorted_timeout_queue
module stq_checker import stq_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [HANDLE_W-1:0] rsp_released_handle,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_last_of_run
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_released_handle)
         && $stable(rsp_status) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // insert results are single transfers
   a_insert_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_RELEASED) |-> rsp_last_of_run)
      else $error("insert result without last flag");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_RELEASED) || (rsp_status == STATUS_ACCEPTED)
         || (rsp_status == STATUS_REJECTED))
      else $error("undefined status code");

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a run that is not finished keeps the request side closed
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("request taken in the middle of a release run");

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_released_handle (rsp_released_handle),
   .rsp_status          (rsp_status),
   .rsp_last_of_run     (rsp_last_of_run)
);

[sim/tb_sorted_timeout_queue.sv]
// testbench for sorted_timeout_queue: directed and random insert/service transfers,
// results checked in order against a sorted expiry list kept in a small scoreboard class
// depends on stq_pkg and the sorted_timeout_queue rtl
module tb_sorted_timeout_queue;
   import stq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 200;   // long receiver stall, backs up the requests
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no transfer on either side
   localparam int DRAIN_CYCLES    = 20;    // quiet time after the last expected result
   localparam int IDLE_PERCENT    = 14;

   // one expected result transfer
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [STATUS_W-1:0] status;
      logic                last;
   } outcome_type;

   // keeps its own sorted copy of the pending entries and the results they will cause
   class release_order_board;
      logic [HANDLE_W-1:0] slot_handle [QUEUE_DEPTH];
      logic [TIME_W-1:0]   slot_expiry [QUEUE_DEPTH];
      int                  occupied;
      outcome_type         due_results [$];
      int                  failures;

      function new();
         occupied = 0;
         failures = 0;
      endfunction

      // called on every accepted request transfer
      function void note_request(input logic op, input logic [HANDLE_W-1:0] handle,
                                 input logic [TIME_W-1:0] delay,
                                 input logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] expiry;
         int                pos;
         int                n;
         int                i;
         expiry = delay + now;  // wraps modulo 2^32 on purpose
         if (op == OP_INSERT) begin
            if (occupied >= QUEUE_DEPTH) begin
               due_results.push_back(outcome_type'{handle, STATUS_REJECTED, 1'b1});
            end else begin
               // goes behind every entry with an equal or earlier expiry
               pos = 0;
               while (pos < occupied && slot_expiry[pos] <= expiry) pos++;
               for (i = occupied; i > pos; i--) begin
                  slot_handle[i] = slot_handle[i-1];
                  slot_expiry[i] = slot_expiry[i-1];
               end
               slot_handle[pos] = handle;
               slot_expiry[pos] = expiry;
               occupied++;
               due_results.push_back(outcome_type'{handle, STATUS_ACCEPTED, 1'b1});
            end
         end else begin
            n = 0;
            while (n < occupied && n < MAX_RESULTS && slot_expiry[n] <= now) n++;
            for (i = 0; i < n; i++) begin
               due_results.push_back(outcome_type'{slot_handle[i], STATUS_RELEASED,
                                                   i == n - 1});
            end
            for (i = 0; i < occupied - n; i++) begin
               slot_handle[i] = slot_handle[i+n];
               slot_expiry[i] = slot_expiry[i+n];
            end
            occupied -= n;
         end
      endfunction

      // called on every accepted result transfer
      function void check_release(input logic [HANDLE_W-1:0] handle,
                                  input logic [STATUS_W-1:0] status, input logic last);
         outcome_type want;
         if (due_results.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: unexpected result handle %0d status %0d last %0b",
                        $realtime, handle, status, last);
            end
         end else begin
            want = due_results.pop_front();
            if (want.handle !== handle || want.status !== status || want.last !== last) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: expected handle %0d status %0d last %0b, got %0d %0d %0b",
                           $realtime, want.handle, want.status, want.last,
                           handle, status, last);
               end
            end
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_operation;
   logic [HANDLE_W-1:0] req_message_handle;
   logic [TIME_W-1:0]   req_delay_ticks;
   logic [TIME_W-1:0]   req_current_time;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [HANDLE_W-1:0] rsp_released_handle;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last_of_run;

   release_order_board board = new();

   logic steady           = 1'b0;  // both sides stop idling while set
   logic hold_off_request = 1'b0;  // asks the receiver for one long stall
   int   quiet_cycles     = 0;

   sorted_timeout_queue dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_message_handle  (req_message_handle),
      .req_delay_ticks     (req_delay_ticks),
      .req_current_time    (req_current_time),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_released_handle (rsp_released_handle),
      .rsp_status          (rsp_status),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            board.note_request(req_operation, req_message_handle, req_delay_ticks,
                               req_current_time);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_release(rsp_released_handle, rsp_status, rsp_last_of_run);
         end
         // any transfer restarts the watchdog count
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: ends the run when transfers stop for too long
   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   // receiver: random back-pressure, plus one long stall on request
   initial begin
      int held;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // one request transfer; returns right after the accepting edge
   task automatic send_request(input logic op, input logic [HANDLE_W-1:0] handle,
                               input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] now);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_message_handle <= handle;
      req_delay_ticks    <= delay;
      req_current_time   <= now;
      do @(posedge clock); while (!req_ready);
   endtask

   // mostly well-formed traffic: short delays against an advancing tick count,
   // with a little full-range noise mixed in
   task automatic send_mixed(inout logic [TIME_W-1:0] tick);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         send_request(1'($urandom), HANDLE_W'($urandom), $urandom, $urandom);
      end else if (roll < 55) begin
         send_request(OP_INSERT, HANDLE_W'($urandom_range(0, 31)), $urandom_range(0, 60), tick);
      end else begin
         tick = tick + $urandom_range(0, 25);
         send_request(OP_SERVICE, HANDLE_W'($urandom), $urandom, tick);
      end
   endtask

   initial begin
      logic [TIME_W-1:0] tick;
      int                k;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_INSERT;
      req_message_handle = '0;
      req_delay_ticks    = '0;
      req_current_time   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: empty service, extremes, wrap, ties, partial and multi releases
      send_request(OP_SERVICE, 5'd0, 32'd0, 32'd0);               // nothing to release
      send_request(OP_INSERT, 5'd0, 32'd0, 32'd0);
      send_request(OP_INSERT, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // expiry wraps
      send_request(OP_INSERT, 5'd5, 32'd10, 32'd0);
      send_request(OP_INSERT, 5'd6, 32'd5, 32'd5);                 // tie keeps order
      send_request(OP_INSERT, 5'd7, 32'd0, 32'd10);                // tie again
      send_request(OP_INSERT, 5'd8, 32'd3, 32'd0);                 // lands mid-queue
      send_request(OP_SERVICE, 5'd31, 32'hFFFF_FFFF, 32'd2);
      send_request(OP_SERVICE, 5'd0, 32'd0, 32'd9);
      send_request(OP_SERVICE, 5'd0, 32'd0, 32'd10);               // three equal expiries
      send_request(OP_SERVICE, 5'd0, 32'd0, 32'd10);               // nothing left due
      send_request(OP_INSERT, 5'd1, 32'hFFFF_FFFF, 32'd0);
      send_request(OP_INSERT, 5'd2, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_SERVICE, 5'd0, 32'd0, 32'hFFFF_FFFE);
      send_request(OP_SERVICE, 5'd0, 32'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 5'd3, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_INSERT, 5'd4, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(OP_INSERT, 5'd9, 32'hAAAA_AAAA, 32'h5555_5555);
      send_request(OP_SERVICE, 5'd21, 32'h1234_5678, 32'hFFFF_FFFF);

      // random traffic, with a stretch where neither side idles
      tick = $urandom_range(0, 1000);
      for (k = 0; k < 50; k++) begin
         steady = (k >= 20 && k < 45);
         send_mixed(tick);
      end
      steady = 1'b0;

      // receiver stalls while inserts keep coming; the queue fills and rejects
      hold_off_request = 1'b1;
      for (k = 0; k < 34; k++) begin
         send_request(OP_INSERT, HANDLE_W'($urandom), $urandom, $urandom);
      end
      // everything is due at the top of the time range: a full run of releases
      send_request(OP_SERVICE, HANDLE_W'($urandom), $urandom, 32'hFFFF_FFFF);
      send_request(OP_SERVICE, HANDLE_W'($urandom), $urandom, 32'hFFFF_FFFF);

      tick = $urandom_range(0, 1000);
      for (k = 0; k < 20; k++) send_mixed(tick);

      @(negedge clock);
      req_valid <= 1'b0;

      // wait for the remaining results, then give stray ones a chance to show
      while (board.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
